/* design/led_center_fill_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// led center fill sequencer assertion macros
// shared concurrent assertion forms, clocked on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef LED_CENTER_FILL_SEQUENCER_MACROS_SVH
`define LED_CENTER_FILL_SEQUENCER_MACROS_SVH

// condition holds at every edge outside reset
`define LCFS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LCFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lcfs_pkg.sv */
// ----------------------------------------------------------------------------
// lcfs_pkg
// types and constants shared by the led center fill sequencer and its channels
// ----------------------------------------------------------------------------
package lcfs_pkg;

   // widths of the channel fields and the state
   localparam int MAX_LEDS = 32;
   localparam int MASK_W   = MAX_LEDS;
   localparam int COUNT_W  = 6;
   localparam int CMD_W    = 3;
   localparam int DELAY_W  = 16;
   localparam int STEP_W   = 7;
   localparam int MODE_W   = 2;

   // reset values
   localparam logic [COUNT_W-1:0] LED_COUNT_RESET = COUNT_W'(7);
   localparam logic [DELAY_W-1:0] DELAY_RESET     = DELAY_W'(100);

   // command codes on the request channel
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 3'd0,
      CMD_FILL     = 3'd1,
      CMD_SHUTDOWN = 3'd2,
      CMD_OFF      = 3'd3,
      CMD_ON       = 3'd4
   } cmd_type;

   // animation mode
   typedef enum logic [MODE_W-1:0] {
      MODE_OFF      = 2'd0,
      MODE_ON       = 2'd1,
      MODE_STARTUP  = 2'd2,
      MODE_SHUTDOWN = 2'd3
   } mode_type;

endpackage

/* design/lcfs_req_if.sv */
// ----------------------------------------------------------------------------
// lcfs_req_if
// request channel: a tick or command beat with its step delay
// ----------------------------------------------------------------------------
interface lcfs_req_if;
   import lcfs_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [DELAY_W-1:0] step_delay;

   modport source (output valid, cmd, step_delay, input ready);
   modport sink   (input valid, cmd, step_delay, output ready);
endinterface

/* design/lcfs_rsp_if.sv */
// ----------------------------------------------------------------------------
// lcfs_rsp_if
// response channel: led mask, mode and write strobe for each request beat
// ----------------------------------------------------------------------------
interface lcfs_rsp_if;
   import lcfs_pkg::*;

   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] led_mask;
   logic [MODE_W-1:0] mode_now;
   logic              write_strobe;

   modport source (output valid, led_mask, mode_now, write_strobe, input ready);
   modport sink   (input valid, led_mask, mode_now, write_strobe, output ready);
endinterface

/* design/led_center_fill_sequencer.sv */
// ----------------------------------------------------------------------------
// led_center_fill_sequencer: center-out fill and shutdown animation for one bar
// request beat to response beat through two registers (input reg, result reg)
// throughput one beat per cycle unless rsp ready stalls; state updates in the single compute stage
// synchronous reset: mode off, step 0, elapsed 0, delay 100, mask 0, count 7
// ----------------------------------------------------------------------------
`include "led_center_fill_sequencer_macros.svh"

module led_center_fill_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [lcfs_pkg::COUNT_W-1:0] csr_wdata,
   lcfs_req_if.sink                     req_chan,
   lcfs_rsp_if.source                   rsp_chan
);
   import lcfs_pkg::*;

   // input stage
   logic               s1_valid_ff;
   logic [CMD_W-1:0]   s1_cmd_ff;
   logic [DELAY_W-1:0] s1_delay_ff;

   // result stage
   logic               out_valid_ff;
   logic [MASK_W-1:0]  out_mask_ff;
   mode_type           out_mode_ff;
   logic               out_strobe_ff;

   // sequencer state
   logic [COUNT_W-1:0]       led_count_ff;
   mode_type                 mode_ff, mode_in;
   logic signed [STEP_W-1:0] step_ff, step_in;
   logic [DELAY_W-1:0]       elapsed_ff, elapsed_in;
   logic [DELAY_W-1:0]       delay_ff, delay_in;
   logic [MASK_W-1:0]        mask_ff, mask_in;
   logic                     strobe_in;

   // handshake
   logic advance;
   logic fire;

   // derived values
   logic [COUNT_W-1:0]       n_eff;
   logic [COUNT_W:0]         n_plus;
   logic [COUNT_W-1:0]       total;
   logic [COUNT_W-2:0]       half;
   logic signed [STEP_W+1:0] step_x;
   logic signed [STEP_W+1:0] left_x;
   logic signed [STEP_W+1:0] right_x;
   logic [MASK_W-1:0]        step_bits;
   logic [MASK_W-1:0]        low_mask;
   logic [DELAY_W-1:0]       elapsed_inc;
   logic                     step_due;
   logic                     up_ok;
   logic                     animating;

   // pipeline control
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign fire           = s1_valid_ff && advance;

   // effective count and step total
   assign n_eff  = (led_count_ff > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS) : led_count_ff;
   assign n_plus = {1'b0, n_eff} + 1'b1;
   assign total  = n_plus[COUNT_W:1];
   assign half   = n_eff[COUNT_W-1:1];

   // led pair positions for the current step
   assign step_x  = {{2{step_ff[STEP_W-1]}}, step_ff};
   assign left_x  = {{(STEP_W+3-COUNT_W){1'b0}}, half} - step_x
                    - {{(STEP_W+1){1'b0}}, ~n_eff[0]};
   assign right_x = {{(STEP_W+3-COUNT_W){1'b0}}, half} + step_x;

   // per-led decode of the step pair and of the bar range
   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         low_mask[i]  = COUNT_W'(i) < n_eff;
         step_bits[i] = low_mask[i] &&
                        ((left_x == (STEP_W+2)'(i)) || (right_x == (STEP_W+2)'(i)));
      end
   end

   // tick timing
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign step_due    = elapsed_inc >= delay_ff;
   assign up_ok       = step_ff < $signed({1'b0, total});
   assign animating   = (mode_ff == MODE_STARTUP) || (mode_ff == MODE_SHUTDOWN);

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (cmd_type'(s1_cmd_ff))
         CMD_TICK: begin
            if (mode_ff == MODE_STARTUP && step_due && !up_ok) begin
               mode_in = MODE_ON;
            end else if (mode_ff == MODE_SHUTDOWN && step_due && step_ff[STEP_W-1]) begin
               mode_in = MODE_OFF;
            end
         end
         CMD_FILL:     mode_in = MODE_STARTUP;
         CMD_SHUTDOWN: mode_in = MODE_SHUTDOWN;
         CMD_OFF:      mode_in = MODE_OFF;
         CMD_ON:       mode_in = MODE_ON;
         default:      mode_in = mode_ff;
      endcase
   end

   // next step, timer, delay, mask and strobe
   always_comb begin
      step_in    = step_ff;
      elapsed_in = elapsed_ff;
      delay_in   = delay_ff;
      mask_in    = mask_ff;
      strobe_in  = 1'b0;
      case (cmd_type'(s1_cmd_ff))
         CMD_TICK: begin
            if (animating) begin
               elapsed_in = step_due ? '0 : elapsed_inc;
               if (step_due && mode_ff == MODE_STARTUP && up_ok) begin
                  mask_in   = mask_ff | step_bits;
                  strobe_in = 1'b1;
                  step_in   = step_ff + 1'b1;
               end else if (step_due && mode_ff == MODE_SHUTDOWN && !step_ff[STEP_W-1]) begin
                  mask_in   = mask_ff & ~step_bits;
                  strobe_in = 1'b1;
                  step_in   = step_ff - 1'b1;
               end
            end
         end
         CMD_FILL: begin
            delay_in   = s1_delay_ff;
            elapsed_in = '0;
            step_in    = '0;
            mask_in    = mask_ff & ~low_mask;
            strobe_in  = 1'b1;
         end
         CMD_SHUTDOWN: begin
            delay_in   = s1_delay_ff;
            elapsed_in = '0;
            step_in    = $signed({{(STEP_W-COUNT_W){1'b0}}, total} - 1'b1);
         end
         CMD_OFF: begin
            mask_in   = mask_ff & ~low_mask;
            strobe_in = 1'b1;
         end
         CMD_ON: begin
            mask_in   = mask_ff | low_mask;
            strobe_in = 1'b1;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         led_count_ff <= LED_COUNT_RESET;
         mode_ff      <= MODE_OFF;
         step_ff      <= '0;
         elapsed_ff   <= '0;
         delay_ff     <= DELAY_RESET;
         mask_ff      <= '0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (csr_we) begin
            led_count_ff <= csr_wdata;
         end
         if (fire) begin
            mode_ff    <= mode_in;
            step_ff    <= step_in;
            elapsed_ff <= elapsed_in;
            delay_ff   <= delay_in;
            mask_ff    <= mask_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_cmd_ff   <= req_chan.cmd;
         s1_delay_ff <= req_chan.step_delay;
      end
      if (fire) begin
         out_mask_ff   <= mask_in;
         out_mode_ff   <= mode_in;
         out_strobe_ff <= strobe_in;
      end
   end

   // response beat
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.led_mask     = out_mask_ff;
   assign rsp_chan.mode_now     = out_mode_ff;
   assign rsp_chan.write_strobe = out_strobe_ff;

   // step timer never rests at or above the loaded delay, except at zero
   `LCFS_ASSERT_ALWAYS(a_elapsed_below_delay,
      (elapsed_ff == '0) || (elapsed_ff < delay_ff), "step timer at or above delay")

   // a held input beat stays put while the result stage is blocked
   `LCFS_ASSERT_NEXT(a_input_held, s1_valid_ff && !advance, s1_valid_ff,
      "input beat lost under stall")

   // a processed beat always lands in the result stage
   `LCFS_ASSERT_NEXT(a_result_loaded, fire, out_valid_ff, "processed beat not presented")

   // a tick during shutdown can only keep shutting down or finish off
   `LCFS_ASSERT_NEXT(a_shutdown_exit,
      fire && (s1_cmd_ff == CMD_TICK) && (mode_ff == MODE_SHUTDOWN),
      (mode_ff == MODE_SHUTDOWN) || (mode_ff == MODE_OFF), "shutdown left to a mode other than off")

endmodule
